>>> rtl/i2c_slave_register_relay_core_macros.svh
// Assertion macros used by the relay core.
`ifndef I2C_SLAVE_REGISTER_RELAY_CORE_MACROS_SVH
`define I2C_SLAVE_REGISTER_RELAY_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ISRR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in relay core");
`define ISRR_ASSERT_NEVER(label, clk, rst, cond) \
   `ISRR_ASSERT(label, clk, rst, !(cond))
`else
`define ISRR_ASSERT(label, clk, rst, prop)
`define ISRR_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/i2csrr_pkg.sv
// Types and codes of the I2C slave register relay.
package i2csrr_pkg;

   typedef enum logic [2:0] {
      ST_WAIT_START = 3'd0,
      ST_ERROR      = 3'd1,
      ST_GOT_START  = 3'd2,
      ST_GOT_DEVID  = 3'd3,
      ST_READY      = 3'd4,
      ST_WAIT_STOP  = 3'd5
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_READ  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_STOP  = 3'd4,
      ACT_CLEAR = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      SLP_NONE    = 2'd0,
      SLP_DISABLE = 2'd1,
      SLP_ENABLE  = 2'd2
   } sleep_type;

   localparam logic [7:0] ID_RESET    = 8'hFF;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;

   typedef struct packed {
      logic       start_flag;
      logic       addr_match;
      logic       rx_ready;
      logic       tx_done;
      logic       nack_seen;
      logic       stop_flag;
      logic       stretch_flag;
      logic       host_reading;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [7:0] dev_id;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      sleep_type  sleep_request;
      state_type  next_state;
   } rsp_type;

endpackage

>>> rtl/i2c_slave_register_relay_core.sv
// Top level of the I2C slave register relay: protocol state machine per bus event.
//
//   channel   direction   handshake          payload
//   req       in          req_valid/stall    i2csrr_pkg::req_type
//   rsp       out         rsp_valid/stall    i2csrr_pkg::rsp_type
//
// Each transaction is taken into the input register and leaves through the result
// register, which holds its result until the response side takes it.
// One transaction per cycle while rsp_stall is low; state update is a single pass.
// Reset is synchronous and returns to waiting for start with ids at 0xFF.
// A stalled result holds the pipe; the input register then stalls the request side.
module i2c_slave_register_relay_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  i2csrr_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2csrr_pkg::rsp_type rsp_data
);
   import i2csrr_pkg::*;
`include "i2c_slave_register_relay_core_macros.svh"

   logic       req_valid_ff;
   req_type    req_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   state_type  state_ff, state_in;
   logic [7:0] dev_ff, dev_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] count_ff, count_in;
   logic       advance;
   logic [7:0] count_bump;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign count_bump = count_ff + {7'd0, (count_ff != COUNT_MAX)};

   // Next protocol state.
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         case (state_ff)
            ST_WAIT_START: begin
               if (req_ff.start_flag) state_in = ST_WAIT_START;
               else if (req_ff.addr_match)
                  state_in = req_ff.host_reading ? ST_ERROR : ST_GOT_START;
               else if (!req_ff.stretch_flag) state_in = ST_ERROR;
            end
            ST_GOT_START: begin
               if (req_ff.rx_ready) state_in = ST_GOT_DEVID;
               else if (!req_ff.stretch_flag) state_in = ST_ERROR;
            end
            ST_GOT_DEVID: begin
               if (req_ff.rx_ready) state_in = ST_READY;
               else if (!req_ff.stretch_flag) state_in = ST_ERROR;
            end
            ST_READY: begin
               if (req_ff.start_flag) state_in = ST_READY;
               else if (req_ff.addr_match) begin
                  if (!(req_ff.host_reading && count_ff == 8'd0)) state_in = ST_ERROR;
               end else if (req_ff.rx_ready) state_in = ST_READY;
               else if (req_ff.tx_done) begin
                  if (req_ff.nack_seen) state_in = ST_WAIT_STOP;
               end else if (req_ff.stop_flag) state_in = ST_WAIT_START;
               else if (!req_ff.stretch_flag) state_in = ST_ERROR;
            end
            ST_WAIT_STOP: begin
               if (req_ff.stop_flag) state_in = ST_WAIT_START;
               else if (!req_ff.stretch_flag) state_in = ST_ERROR;
            end
            default: state_in = ST_WAIT_START;
         endcase
      end
   end

   // Actions, sleep requests, write data, held ids and the access count.
   always_comb begin
      dev_in   = dev_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      rsp_in.action        = ACT_NONE;
      rsp_in.write_data    = 8'd0;
      rsp_in.sleep_request = SLP_NONE;
      if (advance) begin
         case (state_ff)
            ST_WAIT_START: begin
               if (req_ff.start_flag) rsp_in.sleep_request = SLP_DISABLE;
            end
            ST_GOT_START: begin
               if (req_ff.rx_ready) begin
                  dev_in        = req_ff.rx_byte;
                  rsp_in.action = ACT_START;
               end
            end
            ST_GOT_DEVID: begin
               if (req_ff.rx_ready) begin
                  addr_in  = req_ff.rx_byte;
                  count_in = 8'd0;
               end
            end
            ST_READY: begin
               if (req_ff.start_flag) rsp_in.sleep_request = SLP_DISABLE;
               else if (req_ff.addr_match) begin
                  if (req_ff.host_reading && count_ff == 8'd0) begin
                     rsp_in.action = ACT_READ;
                     count_in      = count_bump;
                  end
               end else if (req_ff.rx_ready) begin
                  rsp_in.action     = ACT_WRITE;
                  rsp_in.write_data = req_ff.rx_byte;
                  count_in          = count_bump;
               end else if (req_ff.tx_done) begin
                  if (!req_ff.nack_seen) begin
                     rsp_in.action = ACT_READ;
                     count_in      = count_bump;
                  end
               end else if (req_ff.stop_flag) begin
                  rsp_in.action        = ACT_STOP;
                  rsp_in.sleep_request = SLP_ENABLE;
               end
            end
            ST_WAIT_STOP: begin
               if (req_ff.stop_flag) begin
                  rsp_in.action        = ACT_STOP;
                  rsp_in.sleep_request = SLP_ENABLE;
               end
            end
            default: rsp_in.action = ACT_CLEAR;
         endcase
      end
      rsp_in.dev_id     = dev_in;
      rsp_in.reg_addr   = addr_in;
      rsp_in.next_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_WAIT_START;
         dev_ff       <= ID_RESET;
         addr_ff      <= ID_RESET;
         count_ff     <= 8'd0;
      end else begin
         if (!req_stall) req_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         state_ff <= state_in;
         dev_ff   <= dev_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) req_ff <= req_data;
      if (advance) rsp_ff <= rsp_in;
   end

   // A waiting result always reports the state that the engine now holds.
   `ISRR_ASSERT(a_state_matches, clock, reset,
      rsp_valid_ff |-> rsp_ff.next_state == state_ff)
   `ISRR_ASSERT_NEVER(a_wdata_zero, clock, reset,
      rsp_valid_ff && rsp_ff.action != ACT_WRITE && rsp_ff.write_data != 8'd0)
   `ISRR_ASSERT(a_devid_taken, clock, reset,
      (advance && state_ff == ST_GOT_START && req_ff.rx_ready) |=> state_ff == ST_GOT_DEVID)
   `ISRR_ASSERT(a_count_clear, clock, reset,
      (advance && state_ff == ST_GOT_DEVID && req_ff.rx_ready) |=> count_ff == 8'd0)
   `ISRR_ASSERT(a_rsp_hold, clock, reset, (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)

endmodule
